// ===== rtl/core/atcw_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcw_pkg
// Shared types, constants and helpers of the ANSI text console writer.
// ============================================================================
package atcw_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_LINES   = 32;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int LINE_W      = $clog2(MAX_LINES);
    localparam int ADDR_W      = COL_W + LINE_W;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BLANK  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPJ    = 8'h4A;
    localparam logic [7:0] CH_UPH    = 8'h48;
    localparam logic [7:0] CH_LOWM   = 8'h6D;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    localparam logic [7:0] WIDTH_RESET  = 8'd80;
    localparam logic [5:0] HEIGHT_RESET = 6'd25;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [3:0] {
        CL_READ   = 4'd0,
        CL_DIGIT  = 4'd1,
        CL_SEMI   = 4'd2,
        CL_LBRACK = 4'd3,
        CL_ESC    = 4'd4,
        CL_J      = 4'd5,
        CL_H      = 4'd6,
        CL_M      = 4'd7,
        CL_BS     = 4'd8,
        CL_TAB    = 4'd9,
        CL_CR     = 4'd10,
        CL_LF     = 4'd11,
        CL_PRINT  = 4'd12,
        CL_CTRL   = 4'd13
    } cls_t;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [4:0] read_line;
        logic [6:0] read_column;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_line;
        logic [11:0] cursor_offset;
        logic [15:0] cell_value;
        logic [7:0]  attribute_now;
    } result_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        cls_t       cls;
        logic [7:0] code;
        logic [4:0] line;
        logic [6:0] column;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } back_stat_t;

    function automatic logic [2:0] colour_map(input logic [2:0] idx);
        logic [2:0] r;
        begin
            unique case (idx)
                3'd0: r = 3'd0;
                3'd1: r = 3'd4;
                3'd2: r = 3'd2;
                3'd3: r = 3'd6;
                3'd4: r = 3'd1;
                3'd5: r = 3'd5;
                3'd6: r = 3'd3;
                default: r = 3'd7;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/ansi_text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ansi_text_console_writer_unit
// Text console that interprets character bytes and ANSI escape sequences
// into a store of attribute/character cells and reports the cursor.
// ============================================================================
//
// Channel   Direction  Handshake               Payload
// request   in         push / full             item   (in_item_t)
// result    out        empty / pop             result (result_t)
// config    in         APB psel/penable/pready paddr, pwdata, prdata
//
// In the execution unit a request is first decoded, updating the cursor
// (and writing a printable cell), and then its result is formed.
// A clear of the screen writes each of the width times height cells in turn;
// a scroll reads and then writes each cell in use.
// After reset a clearing pass zeroes all 4096 cells, one per cycle; full
// stays high until the pass ends. Configuration writes are taken always.
// A full result register stalls only the execution unit; the front register
// and the two-entry queue keep taking requests until they fill.
//
module ansi_text_console_writer_unit
    import atcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    logic [7:0] width_reg, width_next;
    logic [5:0] height_reg, height_next;
    logic       wr_en;

    back_stat_t stat;
    logic       q_full, q_push, q_valid, q_rd;
    cmd_t       q_in, q_out;

    // Register file: width at byte address 0, height at byte address 4.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en && paddr == ADDR_WIDTH)
            width_next = pwdata[7:0];
        if (wr_en && paddr == ADDR_HEIGHT)
            height_next = pwdata[5:0];
    end

    always_comb
    begin
        if (paddr == ADDR_WIDTH)
            prdata = 32'(width_reg);
        else if (paddr == ADDR_HEIGHT)
            prdata = 32'(height_reg);
        else
            prdata = 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // The front classifies each byte so the back only sees request classes.
    atcw_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .stat   (stat),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // A short queue decouples decoding from the long sweeps of the back.
    atcw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_in),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_valid (q_valid),
        .rd_data (q_out)
    );

    // The back owns the escape state, cursor, attribute and the cell store.
    atcw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_rd          (q_rd),
        .stat          (stat),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

endmodule

// ===== rtl/core/atcw_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcw_front
// Accepts requests, classifies the byte and holds one classified request.
// ============================================================================
module atcw_front
    import atcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    input  back_stat_t stat,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data
);

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic take;

    always_comb
    begin
        cmd_next.code   = item.char_code;
        cmd_next.line   = item.read_line;
        cmd_next.column = item.read_column;
        if (item.command == CMD_READ)
            cmd_next.cls = CL_READ;
        else if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE)
            cmd_next.cls = CL_DIGIT;
        else if (item.char_code == CH_SEMI)
            cmd_next.cls = CL_SEMI;
        else if (item.char_code == CH_LBRACK)
            cmd_next.cls = CL_LBRACK;
        else if (item.char_code == CH_ESC)
            cmd_next.cls = CL_ESC;
        else if (item.char_code == CH_UPJ)
            cmd_next.cls = CL_J;
        else if (item.char_code == CH_UPH)
            cmd_next.cls = CL_H;
        else if (item.char_code == CH_LOWM)
            cmd_next.cls = CL_M;
        else if (item.char_code == CH_BS)
            cmd_next.cls = CL_BS;
        else if (item.char_code == CH_TAB)
            cmd_next.cls = CL_TAB;
        else if (item.char_code == CH_CR)
            cmd_next.cls = CL_CR;
        else if (item.char_code == CH_LF)
            cmd_next.cls = CL_LF;
        else if (item.char_code >= CH_BLANK)
            cmd_next.cls = CL_PRINT;
        else
            cmd_next.cls = CL_CTRL;
    end

    assign full   = stat.init_busy || (valid_reg && q_full);
    assign take   = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_data = cmd_reg;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_next;
    end

endmodule

// ===== rtl/core/atcw_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcw_queue
// Two-entry queue of classified requests between the front and the back.
// ============================================================================
module atcw_queue
    import atcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_data,
    output logic q_full,
    input  logic rd,
    output logic q_valid,
    output cmd_t rd_data
);

    cmd_t       entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign q_full  = cnt_reg[1];
    assign q_valid = cnt_reg != 2'd0;
    assign rd_data = entry_reg[rptr_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && q_valid;

    always_comb
    begin
        wptr_next = do_wr ? ~wptr_reg : wptr_reg;
        rptr_next = do_rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/core/atcw_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// atcw_back
// Executes classified requests on the cell store and produces results.
// ============================================================================
module atcw_back
    import atcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] screen_width,
    input  logic [5:0] screen_height,
    input  logic       q_valid,
    input  cmd_t       q_data,
    output logic       q_rd,
    output back_stat_t stat,
    output logic       empty,
    input  logic       pop,
    output result_t    result
);

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_FIN  = 6'b000100,
        ST_CLR  = 6'b001000,
        ST_SCRD = 6'b010000,
        ST_SCWR = 6'b100000
    } state_t;

    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_ESC  = 3'd1;
    localparam logic [2:0] PH_ARG1 = 3'd2;
    localparam logic [2:0] PH_ARG2 = 3'd3;
    localparam logic [2:0] PH_ARG3 = 3'd4;

    state_t state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    logic [15:0]       a1_reg, a1_next, a2_reg, a2_next, a3_reg, a3_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [7:0]        attr_reg, attr_next;
    logic [COL_W-1:0]  c_reg, c_next;
    logic [LINE_W-1:0] r_reg, r_next;
    logic [LINE_W:0]   n_reg, n_next;
    logic              rd_cmd_reg, rd_cmd_next;
    logic              ovalid_reg, ovalid_next;
    result_t           res_reg, res_next;

    logic [15:0]       mem [1 << ADDR_W];
    logic [15:0]       rd_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [15:0]       mem_wd;

    logic [COL_W:0]    eff_w;
    logic [LINE_W:0]   eff_h;
    logic [COL_W:0]    ccol;
    logic [LINE_W:0]   cline;
    logic              norm, is_put;
    logic [LINE_W+1:0] src_row;
    logic              src_ok, col_last, row_last, init_last;
    logic [15:0]       blank;

    function automatic logic [15:0] add_digit(input logic [15:0] a, input logic [3:0] d);
        logic [19:0] v;
        begin
            v = 20'(a) * 20'd10 + 20'(d);
            return (v > 20'd65535) ? 16'hFFFF : v[15:0];
        end
    endfunction

    function automatic logic [7:0] apply_attr(input logic [7:0] t, input logic [15:0] a);
        logic [7:0] r;
        begin
            r = t;
            if (a == 16'd0)
                r = t & ~8'h08;
            else if (a == 16'd1)
                r = t | 8'h08;
            else if (a >= 16'd30 && a <= 16'd37)
                r = {t[7:3], colour_map(3'(a - 16'd30))};
            else if (a >= 16'd40 && a <= 16'd47)
                r = {t[7], colour_map(3'(a - 16'd40)), t[3:0]};
            return r;
        end
    endfunction

    assign eff_w = (screen_width == 8'd0) ? (COL_W+1)'(1)
                 : ((9'(screen_width) > 9'(MAX_COLUMNS)) ? (COL_W+1)'(MAX_COLUMNS)
                 : (COL_W+1)'(screen_width));
    assign eff_h = (screen_height == 6'd0) ? (LINE_W+1)'(1)
                 : ((7'(screen_height) > 7'(MAX_LINES)) ? (LINE_W+1)'(MAX_LINES)
                 : (LINE_W+1)'(screen_height));

    assign blank     = {attr_reg, CH_BLANK};
    assign src_row   = (LINE_W+2)'(r_reg) + (LINE_W+2)'(n_reg);
    assign src_ok    = src_row < (LINE_W+2)'(eff_h);
    assign col_last  = (COL_W+1)'(c_reg) + (COL_W+1)'(1) >= eff_w;
    assign row_last  = (LINE_W+1)'(r_reg) + (LINE_W+1)'(1) >= eff_h;
    assign init_last = (&r_reg) && (&c_reg);
    assign is_put    = q_data.cls != CL_READ;

    assign stat.init_busy = state_reg == ST_INIT;
    assign empty  = !ovalid_reg;
    assign result = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        a1_next     = a1_reg;
        a2_next     = a2_reg;
        a3_next     = a3_reg;
        col_next    = col_reg;
        line_next   = line_reg;
        attr_next   = attr_reg;
        c_next      = c_reg;
        r_next      = r_reg;
        n_next      = n_reg;
        rd_cmd_next = rd_cmd_reg;
        ovalid_next = ovalid_reg && !pop;
        res_next    = res_reg;
        q_rd        = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = {r_reg, c_reg};
        mem_wd      = blank;
        mem_ra      = {q_data.line, q_data.column};
        norm        = 1'b0;
        ccol        = (COL_W+1)'(col_reg);
        cline       = (LINE_W+1)'(line_reg);

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                mem_wd = 16'd0;
                {r_next, c_next} = {r_reg, c_reg} + ADDR_W'(1);
                if (init_last)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_rd        = 1'b1;
                    state_next  = ST_FIN;
                    rd_cmd_next = !is_put;
                    if (is_put)
                    begin
                        priority case (phase_reg)
                            PH_ESC:
                            begin
                                if (q_data.cls == CL_LBRACK)
                                begin
                                    phase_next = PH_ARG1;
                                    a1_next    = 16'd0;
                                end
                                else
                                    norm = 1'b1;
                            end
                            PH_ARG1:
                            begin
                                phase_next = PH_NONE;
                                if (q_data.cls == CL_DIGIT)
                                begin
                                    phase_next = PH_ARG1;
                                    a1_next    = add_digit(a1_reg, q_data.code[3:0]);
                                end
                                else if (q_data.cls == CL_SEMI)
                                begin
                                    phase_next = PH_ARG2;
                                    a2_next    = 16'd0;
                                end
                                else if (q_data.cls == CL_J && a1_reg == 16'd2)
                                begin
                                    col_next   = '0;
                                    line_next  = '0;
                                    r_next     = '0;
                                    c_next     = '0;
                                    state_next = ST_CLR;
                                end
                                else if (q_data.cls == CL_M)
                                    attr_next = apply_attr(attr_reg, a1_reg);
                            end
                            PH_ARG2:
                            begin
                                phase_next = PH_NONE;
                                if (q_data.cls == CL_DIGIT)
                                begin
                                    phase_next = PH_ARG2;
                                    a2_next    = add_digit(a2_reg, q_data.code[3:0]);
                                end
                                else if (q_data.cls == CL_SEMI)
                                begin
                                    phase_next = PH_ARG3;
                                    a3_next    = 16'd0;
                                end
                                else if (q_data.cls == CL_H)
                                begin
                                    if (a2_reg < 16'(eff_w))
                                        col_next = a2_reg[COL_W-1:0];
                                    if (a1_reg < 16'(eff_h))
                                        line_next = a1_reg[LINE_W-1:0];
                                end
                                else if (q_data.cls == CL_M)
                                    attr_next = apply_attr(apply_attr(attr_reg, a1_reg),
                                                           a2_reg);
                            end
                            PH_ARG3:
                            begin
                                phase_next = PH_NONE;
                                if (q_data.cls == CL_DIGIT)
                                begin
                                    phase_next = PH_ARG3;
                                    a3_next    = add_digit(a3_reg, q_data.code[3:0]);
                                end
                                else if (q_data.cls == CL_M)
                                    attr_next = apply_attr(apply_attr(apply_attr(
                                        attr_reg, a1_reg), a2_reg), a3_reg);
                            end
                            default:
                                norm = 1'b1;
                        endcase

                        if (norm)
                        begin
                            phase_next = PH_NONE;
                            if (q_data.cls == CL_ESC)
                                phase_next = PH_ESC;
                            else
                            begin
                                priority case (q_data.cls)
                                    CL_BS:
                                    begin
                                        if (col_reg != '0)
                                            ccol = (COL_W+1)'(col_reg) - (COL_W+1)'(1);
                                    end
                                    CL_TAB:
                                        ccol = ((COL_W+1)'(col_reg) + (COL_W+1)'(8))
                                             & ~(COL_W+1)'(7);
                                    CL_CR:
                                        ccol = '0;
                                    CL_LF:
                                    begin
                                        ccol  = '0;
                                        cline = (LINE_W+1)'(line_reg) + (LINE_W+1)'(1);
                                    end
                                    CL_CTRL:
                                        ccol = (COL_W+1)'(col_reg);
                                    default:
                                    begin
                                        mem_we = 1'b1;
                                        mem_wa = {line_reg, col_reg};
                                        mem_wd = {attr_reg, q_data.code};
                                        ccol   = (COL_W+1)'(col_reg) + (COL_W+1)'(1);
                                    end
                                endcase
                                if (ccol >= eff_w)
                                begin
                                    ccol  = '0;
                                    cline = cline + (LINE_W+1)'(1);
                                end
                                col_next = ccol[COL_W-1:0];
                                if (cline >= eff_h)
                                begin
                                    n_next     = cline - eff_h + (LINE_W+1)'(1);
                                    line_next  = LINE_W'(eff_h - (LINE_W+1)'(1));
                                    r_next     = '0;
                                    c_next     = '0;
                                    state_next = ST_SCRD;
                                end
                                else
                                    line_next = cline[LINE_W-1:0];
                            end
                        end
                    end
                end
            end

            ST_SCRD:
            begin
                mem_ra     = {src_row[LINE_W-1:0], c_reg};
                state_next = ST_SCWR;
            end

            ST_SCWR, ST_CLR:
            begin
                mem_we = 1'b1;
                mem_wd = (state_reg == ST_SCWR && src_ok) ? rd_q : blank;
                if (state_reg == ST_SCWR)
                    state_next = ST_SCRD;
                if (col_last)
                begin
                    c_next = '0;
                    if (row_last)
                        state_next = ST_FIN;
                    else
                        r_next = r_reg + LINE_W'(1);
                end
                else
                    c_next = c_reg + COL_W'(1);
            end

            ST_FIN:
            begin
                if (!ovalid_reg || pop)
                begin
                    ovalid_next            = 1'b1;
                    res_next.cursor_column = col_reg;
                    res_next.cursor_line   = line_reg;
                    res_next.cursor_offset = 12'(13'(line_reg) * 13'(eff_w)
                                                 + 13'(col_reg));
                    res_next.cell_value    = rd_cmd_reg ? rd_q : 16'd0;
                    res_next.attribute_now = attr_reg;
                    state_next             = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            phase_reg  <= PH_NONE;
            a1_reg     <= '0;
            a2_reg     <= '0;
            a3_reg     <= '0;
            col_reg    <= '0;
            line_reg   <= '0;
            attr_reg   <= ATTR_RESET;
            c_reg      <= '0;
            r_reg      <= '0;
            n_reg      <= '0;
            rd_cmd_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            a1_reg     <= a1_next;
            a2_reg     <= a2_next;
            a3_reg     <= a3_next;
            col_reg    <= col_next;
            line_reg   <= line_next;
            attr_reg   <= attr_next;
            c_reg      <= c_next;
            r_reg      <= r_next;
            n_reg      <= n_next;
            rd_cmd_reg <= rd_cmd_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // The read data is held while a finished request waits for the result slot.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (state_reg != ST_FIN)
            rd_q <= mem[mem_ra];
    end

endmodule

// ===== tb/ansi_text_console_writer_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ansi_text_console_writer_unit_tb
// Self-checking bench for the ANSI text console writer. A clocked driver
// feeds requests from a queue, a clocked monitor pops results and compares
// them field by field against a cycle-free model of the console kept here.
// ============================================================================
module ansi_text_console_writer_unit_tb;
    import atcw_pkg::*;

    localparam int REG_WIDTH  = 0;
    localparam int REG_HEIGHT = 1;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    item;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ansi_text_console_writer_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    // Console model state. Requests are predicted when they are queued, which
    // is fine because the block answers them strictly in order.
    logic [15:0] screen_cells [MAX_LINES*MAX_COLUMNS];
    int unsigned esc_phase;
    int unsigned esc_args [3];
    int unsigned cur_col;
    int unsigned cur_line;
    logic [7:0]  cur_attr;
    int unsigned cfg_width;
    int unsigned cfg_height;

    in_item_t pending_requests [$];
    result_t  expected_results [$];
    int       send_idle_pct;
    int       take_idle_pct;
    bit       failed;

    function automatic int unsigned used_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_COLUMNS) return MAX_COLUMNS;
        return cfg_width;
    endfunction

    function automatic int unsigned used_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_LINES) return MAX_LINES;
        return cfg_height;
    endfunction

    function automatic logic [2:0] sgr_colour(input int unsigned idx);
        logic [2:0] lut [8];
        lut = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
        return lut[idx];
    endfunction

    function automatic void apply_sgr(input int unsigned a);
        if (a == 0) cur_attr[3] = 1'b0;
        else if (a == 1) cur_attr[3] = 1'b1;
        else if (a >= 30 && a <= 37) cur_attr[2:0] = sgr_colour(a - 30);
        else if (a >= 40 && a <= 47) cur_attr[6:4] = sgr_colour(a - 40);
    endfunction

    function automatic int unsigned next_arg(input int unsigned a, input int unsigned d);
        int unsigned v;
        v = a * 10 + d;
        return (v > 65535) ? 65535 : v;
    endfunction

    // Interprets one byte exactly as the console does, including wrap and scroll.
    function automatic void console_put(input logic [7:0] c);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        bit          digit;
        w = used_width();
        h = used_height();
        digit = (c >= CH_ZERO && c <= CH_NINE);
        if (esc_phase == 1 && c == CH_LBRACK) begin
            esc_phase = 2;
            esc_args[0] = 0;
            return;
        end
        if (esc_phase >= 2 && esc_phase <= 4) begin
            if (digit) begin
                esc_args[esc_phase-2] = next_arg(esc_args[esc_phase-2], c - CH_ZERO);
                return;
            end
            if (c == CH_SEMI && esc_phase < 4) begin
                esc_args[esc_phase-1] = 0;
                esc_phase++;
                return;
            end
            if (esc_phase == 2 && c == CH_UPJ && esc_args[0] == 2) begin
                for (int r = 0; r < h; r++)
                    for (int k = 0; k < w; k++)
                        screen_cells[r*MAX_COLUMNS+k] = {cur_attr, CH_BLANK};
                cur_col = 0;
                cur_line = 0;
            end else if (esc_phase == 3 && c == CH_UPH) begin
                if (esc_args[1] < w) cur_col = esc_args[1];
                if (esc_args[0] < h) cur_line = esc_args[0];
            end else if (c == CH_LOWM) begin
                for (int i = 0; i < esc_phase - 1; i++) apply_sgr(esc_args[i]);
            end
            esc_phase = 0;
            return;
        end
        esc_phase = 0;
        if (c == CH_ESC) begin
            esc_phase = 1;
            return;
        end
        if (c == CH_BS) begin
            if (cur_col != 0) cur_col--;
        end else if (c == CH_TAB) begin
            cur_col = (cur_col + 8) & ~32'd7;
        end else if (c == CH_CR) begin
            cur_col = 0;
        end else if (c == CH_LF) begin
            cur_col = 0;
            cur_line++;
        end else if (c >= CH_BLANK) begin
            if (cur_line < MAX_LINES && cur_col < MAX_COLUMNS)
                screen_cells[cur_line*MAX_COLUMNS+cur_col] = {cur_attr, c};
            cur_col++;
        end
        if (cur_col >= w) begin
            cur_col = 0;
            cur_line++;
        end
        if (cur_line >= h) begin
            n = cur_line - h + 1;
            for (int r = 0; r < h; r++)
                for (int k = 0; k < w; k++)
                    screen_cells[r*MAX_COLUMNS+k] = (r + n < h)
                        ? screen_cells[(r+n)*MAX_COLUMNS+k] : {cur_attr, CH_BLANK};
            cur_line = h - 1;
        end
    endfunction

    function automatic result_t console_step(input in_item_t req);
        result_t rsp;
        rsp.cell_value = '0;
        if (req.command == CMD_PUT) console_put(req.char_code);
        else rsp.cell_value = screen_cells[req.read_line*MAX_COLUMNS+req.read_column];
        rsp.cursor_column = cur_col[6:0];
        rsp.cursor_line   = cur_line[4:0];
        rsp.cursor_offset = 12'(cur_line * used_width() + cur_col);
        rsp.attribute_now = cur_attr;
        return rsp;
    endfunction

    task automatic queue_request(input in_item_t req);
        pending_requests.push_back(req);
        expected_results.push_back(console_step(req));
    endtask

    task automatic put_byte(input logic [7:0] c);
        in_item_t req;
        req.command = CMD_PUT;
        req.char_code = c;
        req.read_line = 5'($urandom);
        req.read_column = 7'($urandom);
        queue_request(req);
    endtask

    task automatic put_string(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic read_cell(input int unsigned line, input int unsigned col);
        in_item_t req;
        req.command = CMD_READ;
        req.char_code = 8'($urandom);
        req.read_line = line[4:0];
        req.read_column = col[6:0];
        queue_request(req);
    endtask

    // Waits until every queued request has been answered; any clear or scroll
    // sweep has ended by then, as its result is only formed after the sweep.
    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_requests.size() != 0 || expected_results.size() != 0)
               && guard < 2000000) begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle with pready always high.
    task automatic write_register(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WIDTH) cfg_width = value[7:0];
        else cfg_height = value[5:0];
    endtask

    // Random mix of bytes, cell reads and escape sequences, well-formed and broken.
    task automatic random_traffic(input int count);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                put_byte(8'($urandom_range(32, 255)));
            end else if (kind == 3) begin
                put_byte(8'($urandom_range(0, 31)));
            end else if (kind == 4) begin
                read_cell($urandom_range(0, 31), $urandom_range(0, 127));
            end else if (kind == 5) begin
                put_string($sformatf("\033[%0d;%0dH", $urandom_range(0, 40),
                                     $urandom_range(0, 140)));
            end else if (kind == 6) begin
                put_string($sformatf("\033[%0d;%0d;%0dm", $urandom_range(0, 48),
                                     $urandom_range(28, 48), $urandom_range(0, 48)));
            end else if (kind == 7) begin
                put_byte(CH_LF);
            end else if (kind == 8) begin
                if ($urandom_range(0, 15) == 0) put_string("\033[2J");
                else put_byte(CH_TAB);
            end else begin
                // Broken or odd sequences: lone escape, stray final bytes.
                put_byte(CH_ESC);
                put_byte(8'($urandom));
                if ($urandom_range(0, 1)) put_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Driver: pushes the oldest pending request, idling at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 1'b0;
            item <= '0;
        end else begin
            if (push && !full) void'(pending_requests.pop_front());
            if ((push && full) && pending_requests.size() != 0) begin
                push <= 1'b1;
            end else if (pending_requests.size() != 0
                         && $urandom_range(0, 99) >= send_idle_pct) begin
                push <= 1'b1;
                item <= pending_requests[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks every accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, result);
                    failed = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    if (result.cursor_column !== want.cursor_column)
                        $display("%0t: cursor_column expected %0d actual %0d", $time,
                                 want.cursor_column, result.cursor_column);
                    if (result.cursor_line !== want.cursor_line)
                        $display("%0t: cursor_line expected %0d actual %0d", $time,
                                 want.cursor_line, result.cursor_line);
                    if (result.cursor_offset !== want.cursor_offset)
                        $display("%0t: cursor_offset expected %0d actual %0d", $time,
                                 want.cursor_offset, result.cursor_offset);
                    if (result.cell_value !== want.cell_value)
                        $display("%0t: cell_value expected %h actual %h", $time,
                                 want.cell_value, result.cell_value);
                    if (result.attribute_now !== want.attribute_now)
                        $display("%0t: attribute_now expected %h actual %h", $time,
                                 want.attribute_now, result.attribute_now);
                    if (result !== want) failed = 1'b1;
                end
            end
            pop <= ($urandom_range(0, 99) >= take_idle_pct);
        end
    end

    initial begin
        #500ms;
        $display("ansi_text_console_writer_unit regression: fail");
        $finish;
    end

    initial begin
        failed = 1'b0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        for (int i = 0; i < MAX_LINES*MAX_COLUMNS; i++) screen_cells[i] = '0;
        esc_phase = 0;
        esc_args = '{0, 0, 0};
        cur_col = 0;
        cur_line = 0;
        cur_attr = ATTR_RESET;
        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset geometry: the store reads zero after reset,
        // each handled control code, the colour and bold codes, cursor moves, a
        // lone escape, saturating arguments and reads past the screen edge.
        send_idle_pct = 25;
        take_idle_pct = 69;
        read_cell(31, 127);
        read_cell(0, 0);
        put_byte(8'hFF);
        put_byte(CH_BLANK);
        put_byte(CH_BS);
        put_byte(CH_TAB);
        put_byte(CH_CR);
        put_byte(8'h01);
        put_string("\033[1;31;44m");
        put_string("\033[0;47m");
        put_string("\033[99999999;5H");
        put_string("\033[24;79H");
        put_byte(8'h41);
        put_byte(CH_LF);
        put_byte(CH_ESC);
        put_byte(8'h5A);
        put_string("\033[2J");
        read_cell(0, 0);
        drain();

        // Smallest and largest screens, out-of-range register values, then other sizes.
        write_register(REG_WIDTH, 32'd1);
        write_register(REG_HEIGHT, 32'd1);
        put_string("xyz");
        read_cell(0, 0);
        random_traffic(24);
        drain();
        write_register(REG_WIDTH, 32'd128);
        write_register(REG_HEIGHT, 32'd32);
        random_traffic(58);
        drain();
        write_register(REG_WIDTH, 32'hFFFF_FF00);
        write_register(REG_HEIGHT, 32'hFFFF_FFC0);
        random_traffic(24);
        drain();
        send_idle_pct = 69;
        take_idle_pct = 25;
        write_register(REG_WIDTH, 32'hFF);
        write_register(REG_HEIGHT, 32'h3F);
        random_traffic(46);
        drain();
        write_register(REG_WIDTH, 32'd9);
        write_register(REG_HEIGHT, 32'd3);
        random_traffic(46);
        drain();
        send_idle_pct = 0;
        take_idle_pct = 0;
        write_register(REG_WIDTH, 32'd80);
        write_register(REG_HEIGHT, 32'd25);
        random_traffic(46);
        drain();

        if (!failed)
            $display("ansi_text_console_writer_unit regression: pass");
        else
            $display("ansi_text_console_writer_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/atcw_pkg.sv
rtl/core/atcw_front.sv
rtl/core/atcw_queue.sv
rtl/core/atcw_back.sv
rtl/core/ansi_text_console_writer_unit.sv
tb/ansi_text_console_writer_unit_tb.sv
